// ===== rtl/circular_fifo_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Circular FIFO queue assertion macros
// Shorthand for the clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible in the scope of use.
`ifndef CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH

// The condition implies the property in the same cycle.
`define CFQ_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The condition implies the property in the following cycle.
`define CFQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Field widths, operation and status codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

  localparam int MODE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 9;
  localparam int CAP_W   = 9;

  localparam logic [MODE_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] OP_POP     = 3'd1;
  localparam logic [MODE_W-1:0] OP_BURST   = 3'd2;
  localparam logic [MODE_W-1:0] OP_DISCARD = 3'd3;
  localparam logic [MODE_W-1:0] OP_PEEK    = 3'd4;
  localparam logic [MODE_W-1:0] OP_FLUSH   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ERR   = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] pop_data;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } cfq_result_t;

endpackage

`default_nettype wire

// ===== rtl/cfq_in_if.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfq_in_if;
  import cfq_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DATA_W-1:0]  push_data;
  logic [COUNT_W-1:0] count;
  logic [POS_W-1:0]   position;

  modport source (output valid, output mode, output push_data, output count,
                  output position, input ready);
  modport sink   (input valid, input mode, input push_data, input count,
                  input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfq_out_if.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfq_out_if;
  import cfq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] pop_data;
  logic              last;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, output status, output pop_data, output last,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input pop_data, input last,
                  input fill_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue configuration channel
// Valid/ready write channel for the ring capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfq_cfg_if;
  import cfq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_slot_ram #(
  parameter int DEPTH         = 256,
  parameter int ELEMENT_WIDTH = 32,
  parameter int AW            = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [ELEMENT_WIDTH-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output      logic [ELEMENT_WIDTH-1:0] rd_data
);

  logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfq_out_reg.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire cfq_pkg::cfq_result_t res,
  output      logic                 free,
  cfq_out_if.source                 out_ch
);
  import cfq_pkg::*;

  logic        out_valid_r;
  cfq_result_t res_r;

  // The register can take a new word when empty or when it drains this cycle.
  assign free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.pop_data   = res_r.pop_data;
  assign out_ch.last       = res_r.last;
  assign out_ch.fill_level = res_r.fill_level;

endmodule

`default_nettype wire

// ===== rtl/circular_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue core
// Ring-buffer FIFO with push, pop, burst pop, discard, peek and flush.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Word contents                              Taken when
//   -------  ---  -----------------------------------------  -----------------
//   in_ch    in   mode, push_data, count, position           valid && ready
//   out_ch   out  status, pop_data, last, fill_level         valid && ready
//   cfg_ch   in   data (ring capacity in use)                valid (ready = 1)
//
// Push, discard, flush and every error or empty case load their result in the
// cycle the input word is taken. Pop and peek read the slot memory, then load
// the result once the output register is free. A burst pop streams its words over
// the slot memory's single read port, one word per cycle while output is free.
// Reset is synchronous, clears the indices and the fill count and sets the
// capacity to 256 slots (or the depth, if smaller); the slot memory is not
// cleared, so no clearing pass is needed.
// A stalled result word holds the output register and blocks new input.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue_core #(
  parameter int DEPTH         = 256,
  parameter int ELEMENT_WIDTH = 32,
  parameter int MAX_BURST     = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cfq_in_if.sink    in_ch,
  cfq_out_if.source out_ch,
  cfq_cfg_if.sink   cfg_ch
);
  import cfq_pkg::*;

  // Address width of the slot memory.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width for ring arithmetic: holds DEPTH and any index plus a count.
  localparam int SW = ((AW + 1) > 10) ? (AW + 1) : 10;
  // Effective capacity after reset: 256 slots, or fewer if storage is smaller.
  localparam int CAP_RESET = (DEPTH < 256) ? DEPTH : 256;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

  // Index plus offset, wrapped once at the ring size. The offset is always
  // below the ring size, so one subtraction is enough.
  function automatic logic [SW-1:0] ring_add(input logic [SW-1:0] idx,
                                             input logic [SW-1:0] n,
                                             input logic [SW-1:0] cap);
    logic [SW-1:0] s;
    s = idx + n;
    if (s >= cap) begin
      s = s - cap;
    end
    return s;
  endfunction

  // Control registers.
  state_t             state_r,   state_nxt;
  logic [AW-1:0]      rd_idx_r,  rd_idx_nxt;
  logic [AW-1:0]      wr_idx_r,  wr_idx_nxt;
  logic [FILL_W-1:0]  held_r,    held_nxt;
  logic [SW-1:0]      cap_r,     cap_nxt;
  logic [COUNT_W-1:0] left_r,    left_nxt;
  logic [AW-1:0]      ptr_r,     ptr_nxt;

  // Memory port signals.
  logic                     ram_wr_en;
  logic [ELEMENT_WIDTH-1:0] ram_wr_data;
  logic                     ram_rd_en;
  logic [AW-1:0]            ram_rd_addr;
  logic [ELEMENT_WIDTH-1:0] ram_rd_data;

  // Output register hookup.
  logic        res_load;
  cfq_result_t res;
  logic        out_free;

  logic          in_acc;
  logic [SW-1:0] held_w;
  logic [SW-1:0] cnt_w;
  logic [SW-1:0] pos_w;
  logic [SW-1:0] cfg_w;
  logic [SW-1:0] rd_idx_w;
  logic [SW-1:0] wr_idx_w;
  logic          is_full;
  logic          cnt_bad;
  logic [SW-1:0] rd_after_cnt;
  logic [SW-1:0] rd_after_one;
  logic [SW-1:0] peek_addr;
  logic [SW-1:0] wr_after_one;
  logic [SW-1:0] ptr_after_one;
  logic [63:0]   rd_data_wide;

  // Input is taken only between operations and while the output can load,
  // so an immediate result always has a free output register.
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign held_w   = SW'(held_r);
  assign cnt_w    = SW'(in_ch.count);
  assign pos_w    = SW'(in_ch.position);
  assign cfg_w    = SW'(cfg_ch.data);
  assign rd_idx_w = SW'(rd_idx_r);
  assign wr_idx_w = SW'(wr_idx_r);

  // One slot always stays free, so the queue is full at capacity minus one.
  assign is_full = (held_w + SW'(1)) >= cap_r;
  // A count that exceeds the fill or the burst limit is rejected first.
  assign cnt_bad = (cnt_w > held_w) || (in_ch.count > COUNT_W'(MAX_BURST));

  assign rd_after_cnt  = ring_add(rd_idx_w, cnt_w, cap_r);
  assign rd_after_one  = ring_add(rd_idx_w, SW'(1), cap_r);
  assign peek_addr     = ring_add(rd_idx_w, pos_w, cap_r);
  assign wr_after_one  = ring_add(wr_idx_w, SW'(1), cap_r);
  assign ptr_after_one = ring_add(SW'(ptr_r), SW'(1), cap_r);

  assign ram_wr_data  = ELEMENT_WIDTH'(64'(in_ch.push_data));
  assign rd_data_wide = 64'(ram_rd_data);

  always_comb begin
    state_nxt   = state_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    held_nxt    = held_r;
    cap_nxt     = cap_r;
    left_nxt    = left_r;
    ptr_nxt     = ptr_r;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rd_idx_r;
    res_load    = 1'b0;
    res         = '{status: STAT_OK, pop_data: '0, last: 1'b1, fill_level: held_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            OP_PUSH: begin
              res_load = 1'b1;
              if (is_full) begin
                res.status = STAT_FULL;
              end else begin
                ram_wr_en      = 1'b1;
                wr_idx_nxt     = wr_after_one[AW-1:0];
                held_nxt       = held_r + FILL_W'(1);
                res.fill_level = held_r + FILL_W'(1);
              end
            end
            OP_POP: begin
              if (held_r == '0) begin
                res_load   = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                // The result loads once the slot read returns.
                ram_rd_en  = 1'b1;
                rd_idx_nxt = rd_after_one[AW-1:0];
                held_nxt   = held_r - FILL_W'(1);
                left_nxt   = COUNT_W'(1);
                ptr_nxt    = rd_after_one[AW-1:0];
                state_nxt  = ST_READ;
              end
            end
            OP_BURST: begin
              priority if (cnt_bad) begin
                res_load   = 1'b1;
                res.status = STAT_ERR;
              end else if (held_r == '0) begin
                res_load   = 1'b1;
                res.status = STAT_EMPTY;
              end else if (in_ch.count == '0) begin
                res_load = 1'b1;
              end else begin
                // Fill and read index move to their final values now; the
                // walking pointer streams the slots out one per cycle while output is free.
                ram_rd_en  = 1'b1;
                rd_idx_nxt = rd_after_cnt[AW-1:0];
                held_nxt   = held_r - FILL_W'(in_ch.count);
                left_nxt   = in_ch.count;
                ptr_nxt    = rd_after_one[AW-1:0];
                state_nxt  = ST_READ;
              end
            end
            OP_DISCARD: begin
              res_load = 1'b1;
              priority if (cnt_bad) begin
                res.status = STAT_ERR;
              end else if (held_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                rd_idx_nxt     = rd_after_cnt[AW-1:0];
                held_nxt       = held_r - FILL_W'(in_ch.count);
                res.fill_level = held_r - FILL_W'(in_ch.count);
              end
            end
            OP_PEEK: begin
              if (pos_w >= held_w) begin
                res_load   = 1'b1;
                res.status = STAT_ERR;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = peek_addr[AW-1:0];
                left_nxt    = COUNT_W'(1);
                state_nxt   = ST_READ;
              end
            end
            OP_FLUSH: begin
              res_load       = 1'b1;
              rd_idx_nxt     = wr_idx_r;
              held_nxt       = '0;
              res.fill_level = '0;
            end
            default: begin
              // Unused modes are taken and dropped without a result.
            end
          endcase
        end
      end
      ST_READ: begin
        // The memory holds its read data until the next read, so the word
        // waits there while the output register is stalled.
        if (out_free) begin
          res_load     = 1'b1;
          res.pop_data = rd_data_wide[DATA_W-1:0];
          res.last     = (left_r == COUNT_W'(1));
          if (left_r == COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_r;
            ptr_nxt     = ptr_after_one[AW-1:0];
            left_nxt    = left_r - COUNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A capacity write resets the ring; send it only while idle (not enforced).
    if (cfg_ch.valid) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      held_nxt   = '0;
      if (cfg_w < SW'(2)) begin
        cap_nxt = SW'(2);
      end else if (cfg_w > SW'(DEPTH)) begin
        cap_nxt = SW'(DEPTH);
      end else begin
        cap_nxt = cfg_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      held_r   <= '0;
      cap_r    <= SW'(CAP_RESET);
      left_r   <= '0;
      ptr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      held_r   <= held_nxt;
      cap_r    <= cap_nxt;
      left_r   <= left_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  cfq_slot_ram #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .AW            (AW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cfq_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_load),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// Circular FIFO queue port checker
// Watches the core's ports and flags result words that break its rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_fifo_queue_core_macros.svh"

module cfq_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [cfq_pkg::STAT_W-1:0] out_status,
  input wire logic [cfq_pkg::DATA_W-1:0] out_pop_data,
  input wire logic                       out_last,
  input wire logic [cfq_pkg::FILL_W-1:0] out_fill_level
);
  import cfq_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && in_ready;

  // A stalled result word stays put.
  `CFQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_pop_data) && $stable(out_last) && $stable(out_fill_level), "stalled result word changed")

  // No input word is taken while a result word is stalled.
  `CFQ_ASSERT_NOW(a_in_blocked, out_valid && !out_ready, !in_seen, "input taken during output stall")

  // Only a burst pop gives words before its last one, and those are all ok.
  `CFQ_ASSERT_NOW(a_mid_burst_ok, out_valid && !out_last, out_status == STAT_OK, "non-final result word without ok status")

  // An empty report always comes with an empty queue.
  `CFQ_ASSERT_NOW(a_empty_fill, out_valid && (out_status == STAT_EMPTY), out_fill_level == '0, "empty status with nonzero fill level")

endmodule

bind circular_fifo_queue_core cfq_checker u_cfq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_pop_data   (out_ch.pop_data),
  .out_last       (out_ch.last),
  .out_fill_level (out_ch.fill_level)
);

`default_nettype wire
